### rtl/hds_pkg.sv
package hds_pkg;

  // Fixed field widths
  localparam int COEF_W    = 16;
  localparam int SIZE_W    = 8;
  localparam int IDX_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_BITS = 16;

  // Register reset values
  localparam logic [COEF_W-1:0] COEF_RESET = 16'd6554;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd100;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd3;

  typedef struct packed {
    logic [COEF_W-1:0] coef_x;
    logic [COEF_W-1:0] coef_y;
    logic [SIZE_W-1:0] rows_in_use;
    logic [SIZE_W-1:0] cols_in_use;
  } cfg_regs_t;

  // Classification of one accepted cell, carried from front to back
  typedef struct packed {
    logic             interior;    // emitted upper cell gets the stencil update
    logic             has_prev;    // emits the cell one row up
    logic             has_self;    // last row: emits the incoming cell too
    logic             frame_done;  // incoming cell is the last cell of its row
    logic [IDX_W-1:0] row;         // row of the incoming cell
    logic [IDX_W-1:0] col;         // column of the incoming cell
  } cell_meta_t;

  localparam int META_W = $bits(cell_meta_t);

endpackage

### rtl/hds_front.sv
module hds_front #(
  parameter int MAX_COLS   = 128,
  parameter int MAX_ROWS   = 128,
  parameter int VALUE_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hds_pkg::cfg_regs_t     cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_BITS-1:0]  in_cell,
  input  logic                   q_full,
  output logic                   push,
  output hds_pkg::cell_meta_t    push_meta,
  output logic [VALUE_BITS-1:0]  push_cell,
  output logic [VALUE_BITS-1:0]  push_mid,
  output logic [VALUE_BITS-1:0]  push_up,
  output logic [VALUE_BITS-1:0]  push_left,
  output logic [VALUE_BITS-1:0]  push_right
);

  localparam int VB     = VALUE_BITS;
  localparam int IW     = hds_pkg::IDX_W;
  localparam int SZW    = hds_pkg::SIZE_W;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CSZ_W  = (CW + 2 > SZW) ? CW + 2 : SZW;
  localparam int RSZ_W  = (RW + 2 > SZW) ? RW + 2 : SZW;
  localparam logic [CSZ_W-1:0] COLS_TOP = CSZ_W'(MAX_COLS);
  localparam logic [RSZ_W-1:0] ROWS_TOP = RSZ_W'(MAX_ROWS);
  localparam logic [CW-1:0]    COL_END  = CW'(MAX_COLS - 1);

  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CSZ_W-1:0] cols_raw, cols_eff, c_ext;
  logic [RSZ_W-1:0] rows_raw, rows_eff, r_ext;
  logic             last_col, last_row, interior, has_prev, accept;
  logic [CW-1:0]    next_col, next_col_p1;

  // Line buffers and their prefetched read data
  logic [VB-1:0] upper_mem  [MAX_COLS];
  logic [VB-1:0] middle_mem [MAX_COLS];
  logic [VB-1:0] up_rd_r, mid_rd_r, right_rd_r, left_r;

  // Clamp the frame size
  always_comb begin
    cols_raw = CSZ_W'(cfg.cols_in_use);
    rows_raw = RSZ_W'(cfg.rows_in_use);
    priority if (cols_raw < CSZ_W'(3)) cols_eff = CSZ_W'(3);
    else if (cols_raw > COLS_TOP)      cols_eff = COLS_TOP;
    else                               cols_eff = cols_raw;
    priority if (rows_raw < RSZ_W'(3)) rows_eff = RSZ_W'(3);
    else if (rows_raw > ROWS_TOP)      rows_eff = ROWS_TOP;
    else                               rows_eff = rows_raw;
  end

  // Classify the incoming cell
  assign c_ext    = CSZ_W'(col_r);
  assign r_ext    = RSZ_W'(row_r);
  assign last_col = (c_ext + CSZ_W'(1)) >= cols_eff;
  assign last_row = (r_ext + RSZ_W'(1)) >= rows_eff;
  assign has_prev = (row_r != '0);
  assign interior = (r_ext >= RSZ_W'(2)) && ((r_ext + RSZ_W'(1)) <= rows_eff) &&
                    (col_r != '0) && ((c_ext + CSZ_W'(2)) <= cols_eff);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Advance the raster position
  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Prefetch the neighbors of the next cell
  assign next_col    = col_nxt;
  assign next_col_p1 = (next_col == COL_END) ? '0 : next_col + CW'(1);

  // Shift the column down one row and read ahead for the next item
  always_ff @(posedge clk) begin
    if (accept) begin
      upper_mem[col_r]  <= mid_rd_r;
      middle_mem[col_r] <= in_cell;
      up_rd_r           <= upper_mem[next_col];
      mid_rd_r          <= middle_mem[next_col];
      right_rd_r        <= middle_mem[next_col_p1];
      left_r            <= mid_rd_r;
    end
  end

  // Hand the classified cell to the queue
  assign push                 = accept && (has_prev || last_row);
  assign push_meta.interior   = interior;
  assign push_meta.has_prev   = has_prev;
  assign push_meta.has_self   = last_row;
  assign push_meta.frame_done = last_col;
  assign push_meta.row        = IW'(row_r);
  assign push_meta.col        = IW'(col_r);
  assign push_cell            = in_cell;
  assign push_mid             = mid_rd_r;
  assign push_up              = up_rd_r;
  assign push_left            = left_r;
  assign push_right           = right_rd_r;

endmodule

### rtl/hds_queue.sv
module hds_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_END = PW'(DEPTH - 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  count_r;

  assign full      = (count_r == CNTW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  // Store an item
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Move pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_END) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_END) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNTW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNTW'(1);
      end
    end
  end

endmodule

### rtl/hds_back.sv
module hds_back #(
  parameter int VALUE_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hds_pkg::cfg_regs_t            cfg,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  hds_pkg::cell_meta_t           q_meta,
  input  logic signed [VALUE_BITS-1:0]  q_cell,
  input  logic signed [VALUE_BITS-1:0]  q_mid,
  input  logic signed [VALUE_BITS-1:0]  q_up,
  input  logic signed [VALUE_BITS-1:0]  q_left,
  input  logic signed [VALUE_BITS-1:0]  q_right,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [VALUE_BITS-1:0]         out_cell,
  output logic [hds_pkg::IDX_W-1:0]     out_row,
  output logic [hds_pkg::IDX_W-1:0]     out_col,
  output logic                          out_sat,
  output logic                          out_last,
  output logic                          out_done
);

  localparam int VB   = VALUE_BITS;
  localparam int IW   = hds_pkg::IDX_W;
  localparam int KW   = hds_pkg::COEF_W;
  localparam int FB   = hds_pkg::FRAC_BITS;
  localparam int DW   = VB + 2;           // second difference
  localparam int LO_W = DW / 2;           // low partial-product slice
  localparam int HI_W = DW - LO_W;        // high, signed slice
  localparam int PLW  = LO_W + KW;
  localparam int PHW  = HI_W + KW + 1;
  localparam int PW   = DW + KW + 1;      // full product
  localparam int SW   = DW + 2;           // final sum
  localparam logic [VB-1:0] VAL_MAX = {1'b0, {(VB - 1){1'b1}}};
  localparam logic [VB-1:0] VAL_MIN = {1'b1, {(VB - 1){1'b0}}};

  logic free1, free2, free3, free4, free5;

  // Stage 1: second differences
  logic                    v1_r;
  hds_pkg::cell_meta_t     meta1_r;
  logic signed [VB-1:0]    u1_r;
  logic [VB-1:0]           self1_r;
  logic signed [DW-1:0]    dv1_r, dh1_r, twice, dv_nxt, dh_nxt;

  // Stage 2: partial products
  logic                    v2_r;
  hds_pkg::cell_meta_t     meta2_r;
  logic signed [VB-1:0]    u2_r;
  logic [VB-1:0]           self2_r;
  logic [PLW-1:0]          pvl2_r, phl2_r, pvl_nxt, phl_nxt;
  logic signed [PHW-1:0]   pvh2_r, phh2_r, pvh_nxt, phh_nxt;
  logic signed [KW:0]      cx_s, cy_s;

  // Stage 3: combined, truncated products
  logic                    v3_r;
  hds_pkg::cell_meta_t     meta3_r;
  logic signed [VB-1:0]    u3_r;
  logic [VB-1:0]           self3_r;
  logic signed [PW-1:0]    pv_full, ph_full;
  logic signed [DW-1:0]    tv3_r, th3_r;

  // Stage 4: sum and clip
  logic                    v4_r;
  hds_pkg::cell_meta_t     meta4_r;
  logic [VB-1:0]           res4_r, self4_r, res_nxt;
  logic                    sat4_r, ovf;
  logic signed [SW-1:0]    sum;
  logic [SW-VB:0]          top_bits;

  // Output stage with one pending self result
  logic                    out_valid_r, pend_r;
  logic [VB-1:0]           out_cell_r, pend_cell_r;
  logic [IW-1:0]           out_row_r, out_col_r, pend_row_r, pend_col_r;
  logic                    out_sat_r, out_last_r, out_done_r, pend_done_r;

  // Stall chain: a stage loads when it is empty or its contents move on
  assign free5 = !out_valid_r || (out_ready && !pend_r);
  assign free4 = !v4_r || free5;
  assign free3 = !v3_r || free4;
  assign free2 = !v2_r || free3;
  assign free1 = !v1_r || free2;
  assign q_pop = q_valid && free1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (free1) v1_r <= q_valid;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
      if (free4) v4_r <= v3_r;
    end
  end

  // Stage 1
  assign twice  = DW'(q_mid) <<< 1;
  assign dv_nxt = DW'(q_up) + DW'(q_cell) - twice;
  assign dh_nxt = DW'(q_left) + DW'(q_right) - twice;

  always_ff @(posedge clk) begin
    if (free1) begin
      meta1_r <= q_meta;
      u1_r    <= q_mid;
      self1_r <= q_cell;
      dv1_r   <= dv_nxt;
      dh1_r   <= dh_nxt;
    end
  end

  // Stage 2: split each difference into an unsigned low and a signed high slice
  assign cx_s    = signed'({1'b0, cfg.coef_x});
  assign cy_s    = signed'({1'b0, cfg.coef_y});
  assign pvl_nxt = PLW'(dv1_r[LO_W-1:0]) * PLW'(cfg.coef_x);
  assign phl_nxt = PLW'(dh1_r[LO_W-1:0]) * PLW'(cfg.coef_y);
  assign pvh_nxt = PHW'(signed'(dv1_r[DW-1:LO_W])) * PHW'(cx_s);
  assign phh_nxt = PHW'(signed'(dh1_r[DW-1:LO_W])) * PHW'(cy_s);

  always_ff @(posedge clk) begin
    if (free2) begin
      meta2_r <= meta1_r;
      u2_r    <= u1_r;
      self2_r <= self1_r;
      pvl2_r  <= pvl_nxt;
      phl2_r  <= phl_nxt;
      pvh2_r  <= pvh_nxt;
      phh2_r  <= phh_nxt;
    end
  end

  // Stage 3: join slices, drop the fraction (floor)
  assign pv_full = (PW'(pvh2_r) <<< LO_W) + signed'(PW'(pvl2_r));
  assign ph_full = (PW'(phh2_r) <<< LO_W) + signed'(PW'(phl2_r));

  always_ff @(posedge clk) begin
    if (free3) begin
      meta3_r <= meta2_r;
      u3_r    <= u2_r;
      self3_r <= self2_r;
      tv3_r   <= pv_full[FB+DW-1:FB];
      th3_r   <= ph_full[FB+DW-1:FB];
    end
  end

  // Stage 4: add both terms and saturate; boundary cells pass through
  assign sum      = SW'(u3_r) + SW'(tv3_r) + SW'(th3_r);
  assign top_bits = sum[SW-1:VB-1];
  assign ovf      = !((&top_bits) || !(|top_bits));

  always_comb begin
    res_nxt = u3_r;
    if (meta3_r.interior) begin
      if (ovf) begin
        res_nxt = sum[SW-1] ? VAL_MIN : VAL_MAX;
      end else begin
        res_nxt = sum[VB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free4) begin
      meta4_r <= meta3_r;
      res4_r  <= res_nxt;
      sat4_r  <= meta3_r.interior && ovf;
      self4_r <= self3_r;
    end
  end

  // Output stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (free5) begin
      out_valid_r <= v4_r;
      pend_r      <= v4_r && meta4_r.has_prev && meta4_r.has_self;
    end else if (out_ready && pend_r) begin
      pend_r <= 1'b0;
    end
  end

  // Output stage payload: upper cell first, then the last-row cell itself
  always_ff @(posedge clk) begin
    if (free5) begin
      if (meta4_r.has_prev) begin
        out_cell_r <= res4_r;
        out_row_r  <= meta4_r.row - IW'(1);
        out_col_r  <= meta4_r.col;
        out_sat_r  <= sat4_r;
        out_last_r <= !meta4_r.has_self;
        out_done_r <= 1'b0;
      end else begin
        out_cell_r <= self4_r;
        out_row_r  <= meta4_r.row;
        out_col_r  <= meta4_r.col;
        out_sat_r  <= 1'b0;
        out_last_r <= 1'b1;
        out_done_r <= meta4_r.frame_done;
      end
      pend_cell_r <= self4_r;
      pend_row_r  <= meta4_r.row;
      pend_col_r  <= meta4_r.col;
      pend_done_r <= meta4_r.frame_done;
    end else if (out_ready && pend_r) begin
      out_cell_r <= pend_cell_r;
      out_row_r  <= pend_row_r;
      out_col_r  <= pend_col_r;
      out_sat_r  <= 1'b0;
      out_last_r <= 1'b1;
      out_done_r <= pend_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_cell  = out_cell_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_sat   = out_sat_r;
  assign out_last  = out_last_r;
  assign out_done  = out_done_r;

endmodule

### rtl/heat_diffusion_stencil.sv
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_index (register), cfg_data
// in        in         in_tvalid/in_tready  in_tdata: cell_in
// out       out        out_tvalid/out_tready
//                                           out_tdata: cell_out, out_row, out_col
//                                           out_tuser: saturated, frame_done
//                                           out_tlast: last_in_run
//
// Takes one cell per cycle while the queue is not full; the line buffers are read
// one item ahead, so each cell needs one read of the upper buffer and two of the
// middle buffer. Last-row cells give two results each, so there the single output
// port limits the input. Each cell passes the queue, four math stages and output.
// Reset clears position counters, queue and pipeline and loads default registers;
// line buffers are not cleared. A low out_tready freezes the back end; the
// four-entry queue fills before in_tready drops.
module heat_diffusion_stencil #(
  parameter int MAX_COLS   = 128,
  parameter int MAX_ROWS   = 128,
  parameter int VALUE_BITS = 48,
  localparam int IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((VALUE_BITS + 2 * hds_pkg::IDX_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hds_pkg::COEF_W-1:0]        cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_TDATA_W-1:0]             in_tdata,   // cell_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [OUT_TDATA_W-1:0]            out_tdata,  // cell_out, out_row, out_col
  output logic [1:0]                        out_tuser,  // saturated, frame_done
  output logic                              out_tlast   // last_in_run
);

  localparam int VB      = VALUE_BITS;
  localparam int IW      = hds_pkg::IDX_W;
  localparam int QDEPTH  = 4;
  localparam int ENTRY_W = hds_pkg::META_W + 5 * VB;
  localparam int PAD_W   = OUT_TDATA_W - VB - 2 * IW;

  hds_pkg::cfg_regs_t  cfg_r;
  hds_pkg::cell_meta_t push_meta, pop_meta;
  logic                push, q_full, q_pop, q_not_empty;
  logic [VB-1:0]       push_cell, push_mid, push_up, push_left, push_right;
  logic [VB-1:0]       pop_cell, pop_mid, pop_up, pop_left, pop_right;
  logic [ENTRY_W-1:0]  push_entry, pop_entry;
  logic [VB-1:0]       res_cell;
  logic [IW-1:0]       res_row, res_col;
  logic                res_sat, res_last, res_done;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_x      <= hds_pkg::COEF_RESET;
      cfg_r.coef_y      <= hds_pkg::COEF_RESET;
      cfg_r.rows_in_use <= hds_pkg::SIZE_RESET;
      cfg_r.cols_in_use <= hds_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hds_pkg::REG_COEF_X: cfg_r.coef_x      <= cfg_data;
        hds_pkg::REG_COEF_Y: cfg_r.coef_y      <= cfg_data;
        hds_pkg::REG_ROWS:   cfg_r.rows_in_use <= cfg_data[hds_pkg::SIZE_W-1:0];
        hds_pkg::REG_COLS:   cfg_r.cols_in_use <= cfg_data[hds_pkg::SIZE_W-1:0];
        default:             cfg_r             <= cfg_r;
      endcase
    end
  end

  hds_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cell    (in_tdata[VB-1:0]),
    .q_full     (q_full),
    .push       (push),
    .push_meta  (push_meta),
    .push_cell  (push_cell),
    .push_mid   (push_mid),
    .push_up    (push_up),
    .push_left  (push_left),
    .push_right (push_right)
  );

  // Pack and unpack queue entries
  assign push_entry = {push_meta, push_cell, push_mid, push_up, push_left, push_right};
  assign {pop_meta, pop_cell, pop_mid, pop_up, pop_left, pop_right} = pop_entry;

  hds_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .not_empty (q_not_empty)
  );

  hds_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_not_empty),
    .q_pop     (q_pop),
    .q_meta    (pop_meta),
    .q_cell    (pop_cell),
    .q_mid     (pop_mid),
    .q_up      (pop_up),
    .q_left    (pop_left),
    .q_right   (pop_right),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cell  (res_cell),
    .out_row   (res_row),
    .out_col   (res_col),
    .out_sat   (res_sat),
    .out_last  (res_last),
    .out_done  (res_done)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res_col, res_row, res_cell};
  assign out_tuser = {res_done, res_sat};
  assign out_tlast = res_last;

endmodule
